>>> rtl/ofr_pkg.sv
// ofr_pkg: shared types and constants for the opacity fade ramp
// request and result structs, queue entry, operation codes and back-end states
// no dependencies
package ofr_pkg;

  // defaults for the top-level parameters
  localparam int TYPE_BITS_DEF     = 8;
  localparam int REVISION_BITS_DEF = 32;

  // fixed field widths
  localparam int TICK_W      = 64;
  localparam int RAW_W       = 64;
  localparam int UNIT_W      = 33;
  localparam int FIELD_TYPE_W = 8;
  localparam int REV_OUT_W   = 32;
  localparam int ELAPSED_W   = 31;
  localparam int AMOUNT_W    = 64;

  // depth of the queue between front and back
  localparam int QUEUE_DEPTH = 2;

  // unit value and elapsed-tick cap
  localparam logic [UNIT_W-1:0]    ONE_Q       = 33'h1_0000_0000;
  localparam logic [ELAPSED_W-1:0] ELAPSED_CAP = 31'h7FFF_FFFF;

  // request kind codes
  localparam logic [1:0] KIND_ADVANCE  = 2'd0;
  localparam logic [1:0] KIND_SET_TYPE = 2'd1;
  localparam logic [1:0] KIND_SET_FADE = 2'd2;

  // classified operation
  typedef enum logic [1:0] {
    OP_NONE,
    OP_ADVANCE,
    OP_SET_TYPE,
    OP_SET_FADE
  } op_t;

  // back-end sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL,
    ST_APPLY
  } back_state_t;

  typedef struct packed {
    logic [1:0]              kind;
    logic [TICK_W-1:0]       tick;
    logic [FIELD_TYPE_W-1:0] new_decal_type;
    logic                    start_transparent;
    logic signed [RAW_W-1:0] target_opacity_in;
    logic signed [RAW_W-1:0] fade_rate_in;
  } req_t;

  typedef struct packed {
    logic                    present;
    logic [FIELD_TYPE_W-1:0] decal_type;
    logic [UNIT_W-1:0]       opacity;
    logic [UNIT_W-1:0]       fade_target;
    logic [UNIT_W-1:0]       fade_rate;
    logic [REV_OUT_W-1:0]    revision;
  } rsp_t;

  // classified request as held in the queue
  typedef struct packed {
    op_t                     op;
    logic [TICK_W-1:0]       tick;
    logic [FIELD_TYPE_W-1:0] new_type;
    logic                    start_one;
    logic [UNIT_W-1:0]       target;
    logic [UNIT_W-1:0]       rate;
  } entry_t;

endpackage

>>> rtl/ofr_front.sv
// ofr_front: classifies a request and clamps its target and rate
// combinational; uses ofr_pkg
module ofr_front (
  input  ofr_pkg::req_t   req,
  output ofr_pkg::entry_t entry
);

  logic [ofr_pkg::RAW_W-1:0] rate_mag;
  logic [ofr_pkg::RAW_W-1:0] tgt_raw;

  assign tgt_raw  = req.target_opacity_in;
  // magnitude; the most negative value stays 2^63 and saturates below
  assign rate_mag = req.fade_rate_in[ofr_pkg::RAW_W-1]
                  ? (ofr_pkg::RAW_W'(0) - req.fade_rate_in) : req.fade_rate_in;

  always_comb begin
    case (req.kind)
      ofr_pkg::KIND_ADVANCE:  entry.op = ofr_pkg::OP_ADVANCE;
      ofr_pkg::KIND_SET_TYPE: entry.op = ofr_pkg::OP_SET_TYPE;
      ofr_pkg::KIND_SET_FADE: entry.op = ofr_pkg::OP_SET_FADE;
      default:                entry.op = ofr_pkg::OP_NONE;
    endcase

    entry.tick      = req.tick;
    entry.new_type  = req.new_decal_type;
    entry.start_one = !req.start_transparent;

    // target: negative to zero, above one to one
    if (tgt_raw[ofr_pkg::RAW_W-1]) begin
      entry.target = '0;
    end else if (tgt_raw > ofr_pkg::RAW_W'(ofr_pkg::ONE_Q)) begin
      entry.target = ofr_pkg::ONE_Q;
    end else begin
      entry.target = tgt_raw[ofr_pkg::UNIT_W-1:0];
    end

    if (rate_mag > ofr_pkg::RAW_W'(ofr_pkg::ONE_Q)) begin
      entry.rate = ofr_pkg::ONE_Q;
    end else begin
      entry.rate = rate_mag[ofr_pkg::UNIT_W-1:0];
    end
  end

endmodule

>>> rtl/ofr_queue.sv
// ofr_queue: short first-in first-out queue of classified requests
// sits between front and back; uses ofr_pkg
module ofr_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  ofr_pkg::entry_t wr,
  output logic            full,
  input  logic            pop,
  output ofr_pkg::entry_t rd,
  output logic            not_empty
);

  localparam int PTR_W = (ofr_pkg::QUEUE_DEPTH > 1) ? $clog2(ofr_pkg::QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(ofr_pkg::QUEUE_DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(ofr_pkg::QUEUE_DEPTH - 1);

  ofr_pkg::entry_t slots [ofr_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full      = (count == CNT_W'(ofr_pkg::QUEUE_DEPTH));
  assign not_empty = (count != '0);
  assign rd        = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= wr;
    end
  end

endmodule

>>> rtl/ofr_back.sv
// ofr_back: layer state, fade advance and result register
// three-step sequencer (elapsed, multiply, apply); uses ofr_pkg
module ofr_back #(
  parameter int TYPE_BITS     = ofr_pkg::TYPE_BITS_DEF,
  parameter int REVISION_BITS = ofr_pkg::REVISION_BITS_DEF
) (
  input  logic            clk,
  input  logic            rst,
  input  ofr_pkg::entry_t head,
  input  logic            head_valid,
  output logic            pop,
  output logic            rsp_valid,
  output ofr_pkg::rsp_t   rsp,
  input  logic            rsp_stall
);

  localparam int TW = (TYPE_BITS < ofr_pkg::FIELD_TYPE_W) ? TYPE_BITS : ofr_pkg::FIELD_TYPE_W;
  localparam int UW = ofr_pkg::UNIT_W;

  ofr_pkg::back_state_t st, st_next;
  logic commit;

  // layer state
  logic                     present_flag, present_flag_next;
  logic [TW-1:0]            layer_type, layer_type_next;
  logic [UW-1:0]            opacity_reg, opacity_reg_next;
  logic [UW-1:0]            target_reg, target_reg_next;
  logic [UW-1:0]            rate_reg, rate_reg_next;
  logic [ofr_pkg::TICK_W-1:0] last_tick, last_tick_next;
  logic [REVISION_BITS-1:0] revision_count, revision_count_next;

  // work registers
  ofr_pkg::entry_t              cur;
  logic                         later;
  logic [ofr_pkg::ELAPSED_W-1:0] elapsed;
  logic [ofr_pkg::AMOUNT_W-1:0] amount;

  logic [ofr_pkg::TICK_W-1:0]   diff;
  logic                         head_later;
  logic [ofr_pkg::ELAPSED_W-1:0] elapsed_cap;
  logic [ofr_pkg::AMOUNT_W-1:0] product;

  logic [TW-1:0] new_type;
  logic [UW-1:0] start_val;
  logic          adv_en, moving, rising, reach;
  logic [UW-1:0] gap, op_step;
  logic          bump_step, clear_type, bump_type, bump_fade, create;
  logic [TW-1:0] type_adv;
  logic [2:0]    bumps;

  // sequencer
  always_comb begin
    st_next = st;
    case (st)
      ofr_pkg::ST_IDLE:  if (head_valid) st_next = ofr_pkg::ST_MUL;
      ofr_pkg::ST_MUL:   st_next = ofr_pkg::ST_APPLY;
      ofr_pkg::ST_APPLY: if (!rsp_valid || !rsp_stall) st_next = ofr_pkg::ST_IDLE;
      default:           st_next = ofr_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    pop    = 1'b0;
    commit = 1'b0;
    case (st)
      ofr_pkg::ST_IDLE:  pop = head_valid;
      ofr_pkg::ST_APPLY: commit = !rsp_valid || !rsp_stall;
      default: begin
        pop    = 1'b0;
        commit = 1'b0;
      end
    endcase
  end

  // elapsed ticks against the head request
  assign diff        = head.tick - last_tick;
  assign head_later  = head.tick > last_tick;
  assign elapsed_cap = (|diff[ofr_pkg::TICK_W-1:ofr_pkg::ELAPSED_W])
                     ? ofr_pkg::ELAPSED_CAP : diff[ofr_pkg::ELAPSED_W-1:0];

  assign product = {{(ofr_pkg::AMOUNT_W-UW){1'b0}}, rate_reg}
                 * {{(ofr_pkg::AMOUNT_W-ofr_pkg::ELAPSED_W){1'b0}}, elapsed};

  // apply step
  always_comb begin
    new_type  = TW'(cur.new_type);
    start_val = cur.start_one ? ofr_pkg::ONE_Q : '0;

    adv_en = present_flag && ((cur.op == ofr_pkg::OP_ADVANCE) ||
                              (cur.op == ofr_pkg::OP_SET_TYPE) ||
                              ((cur.op == ofr_pkg::OP_SET_FADE) && (layer_type != '0)));
    moving = adv_en && later && (rate_reg != '0) && (opacity_reg != target_reg);
    rising = opacity_reg < target_reg;
    gap    = rising ? (target_reg - opacity_reg) : (opacity_reg - target_reg);
    // amount never exceeds 2^63, so a gap at or below it reaches the target
    reach  = (|amount[ofr_pkg::AMOUNT_W-1:UW]) || (gap <= amount[UW-1:0]);
    if (reach) begin
      op_step = target_reg;
    end else if (rising) begin
      op_step = opacity_reg + amount[UW-1:0];
    end else begin
      op_step = opacity_reg - amount[UW-1:0];
    end
    bump_step  = moving && (op_step != opacity_reg);
    clear_type = moving && (op_step == '0) && (target_reg == '0) && (layer_type != '0);
    type_adv   = clear_type ? '0 : layer_type;

    present_flag_next = present_flag;
    layer_type_next   = type_adv;
    opacity_reg_next  = moving ? op_step : opacity_reg;
    target_reg_next   = target_reg;
    rate_reg_next     = rate_reg;
    last_tick_next    = (adv_en && later) ? cur.tick : last_tick;
    bump_type         = 1'b0;
    bump_fade         = 1'b0;
    create            = 1'b0;

    case (cur.op)
      ofr_pkg::OP_SET_TYPE: begin
        if (!present_flag) begin
          create            = 1'b1;
          present_flag_next = 1'b1;
          layer_type_next   = new_type;
          opacity_reg_next  = start_val;
          target_reg_next   = start_val;
          rate_reg_next     = '0;
          last_tick_next    = cur.tick;
        end else if (type_adv != new_type) begin
          layer_type_next = new_type;
          bump_type       = 1'b1;
          // empty layer gets a fresh opacity
          if (type_adv == '0) begin
            opacity_reg_next = start_val;
            target_reg_next  = start_val;
            rate_reg_next    = '0;
          end
        end
      end
      ofr_pkg::OP_SET_FADE: begin
        if (adv_en && ((target_reg != cur.target) || (rate_reg != cur.rate))) begin
          target_reg_next = cur.target;
          rate_reg_next   = cur.rate;
          bump_fade       = 1'b1;
        end
      end
      default: begin
        create = 1'b0;
      end
    endcase

    bumps = {2'b00, bump_step} + {2'b00, clear_type} + {2'b00, bump_type} + {2'b00, bump_fade};
    revision_count_next = create ? REVISION_BITS'(1)
                                 : revision_count + REVISION_BITS'(bumps);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st             <= ofr_pkg::ST_IDLE;
      rsp_valid      <= 1'b0;
      present_flag   <= 1'b0;
      layer_type     <= '0;
      opacity_reg    <= '0;
      target_reg     <= '0;
      rate_reg       <= '0;
      last_tick      <= '0;
      revision_count <= '0;
    end else begin
      st <= st_next;
      if (commit) begin
        rsp_valid      <= 1'b1;
        present_flag   <= present_flag_next;
        layer_type     <= layer_type_next;
        opacity_reg    <= opacity_reg_next;
        target_reg     <= target_reg_next;
        rate_reg       <= rate_reg_next;
        last_tick      <= last_tick_next;
        revision_count <= revision_count_next;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur     <= head;
      later   <= head_later;
      elapsed <= elapsed_cap;
    end
    if (st == ofr_pkg::ST_MUL) begin
      amount <= product;
    end
    if (commit) begin
      rsp.present     <= present_flag_next;
      rsp.decal_type  <= ofr_pkg::FIELD_TYPE_W'(layer_type_next);
      rsp.opacity     <= opacity_reg_next;
      rsp.fade_target <= target_reg_next;
      rsp.fade_rate   <= rate_reg_next;
      rsp.revision    <= ofr_pkg::REV_OUT_W'(revision_count_next);
    end
  end

  // a new result only ever follows an apply step
  a_rsp_from_apply: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |-> $past(st == ofr_pkg::ST_APPLY))
    else $error("result raised without an apply step");

  // requests are only taken from a non-empty queue
  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    pop |-> head_valid)
    else $error("pop from empty queue");

  // opacity and target never leave the unit range
  a_unit_range: assert property (@(posedge clk) disable iff (rst)
    (opacity_reg <= ofr_pkg::ONE_Q) && (target_reg <= ofr_pkg::ONE_Q))
    else $error("opacity or target above one");

  // creation restarts the revision count at one
  a_create_rev: assert property (@(posedge clk) disable iff (rst)
    (commit && create) |=> (revision_count == REVISION_BITS'(1)))
    else $error("revision not one after creation");

  // once the layer exists its last tick only moves forward
  a_tick_forward: assert property (@(posedge clk) disable iff (rst)
    (present_flag && $past(present_flag)) |-> (last_tick >= $past(last_tick)))
    else $error("last tick moved backwards");

endmodule

>>> rtl/opacity_fade_ramp.sv
// opacity_fade_ramp: top level of the single-layer linear fade ramp
// joins ofr_front, ofr_queue and ofr_back; uses ofr_pkg
//
//   channel | payload | handshake            | role
//   --------+---------+----------------------+------------------------------
//   req     | req_t   | req_valid, req_stall | request in: advance/type/fade
//   rsp     | rsp_t   | rsp_valid, rsp_stall | one result per request
//
// the back end takes each request through three steps: elapsed ticks, the rate-by-elapsed
// multiply, then the apply step; it pops the next request only after that apply step
// a taken request is registered in the queue, then in the work registers, amount and the result
// requests wait in a two-entry queue; req_stall is high only while that queue is full
// a result waiting under rsp_stall holds the back end only at its apply step
// reset (rst, synchronous) empties the queue and clears the layer state
module opacity_fade_ramp #(
  parameter int TYPE_BITS     = ofr_pkg::TYPE_BITS_DEF,
  parameter int REVISION_BITS = ofr_pkg::REVISION_BITS_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_stall,
  input  ofr_pkg::req_t req,
  output logic          rsp_valid,
  input  logic          rsp_stall,
  output ofr_pkg::rsp_t rsp
);

  // classified request from the front
  ofr_pkg::entry_t front_entry;
  // head of the queue towards the back end
  ofr_pkg::entry_t head;
  logic            q_full;
  logic            q_not_empty;
  logic            q_pop;
  logic            q_push;

  // request taken whenever the queue has room
  assign req_stall = q_full;
  assign q_push    = req_valid && !q_full;

  ofr_front u_front (
    .req   (req),
    .entry (front_entry)
  );

  ofr_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .wr        (front_entry),
    .full      (q_full),
    .pop       (q_pop),
    .rd        (head),
    .not_empty (q_not_empty)
  );

  // layer state, fade arithmetic and the result register
  ofr_back #(
    .TYPE_BITS     (TYPE_BITS),
    .REVISION_BITS (REVISION_BITS)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .head       (head),
    .head_valid (q_not_empty),
    .pop        (q_pop),
    .rsp_valid  (rsp_valid),
    .rsp        (rsp),
    .rsp_stall  (rsp_stall)
  );

endmodule
